[hdl/hip_pkg.sv]
// Shared types and constants for the heater interlock, hysteresis controller and pump block.
// Holds the register map, the configuration record and the result record.
// No dependencies.
package hip_pkg;

    // Field widths.
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned DELAY_W = 16;
    localparam int unsigned HYST_W  = 8;
    localparam int unsigned TEMP_W  = 12;
    localparam int unsigned DUTY_W  = 10;
    localparam int unsigned IDX_W   = 3;
    localparam int unsigned DATA_W  = 32;

    // Widths of the packed stream words.
    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 16;

    // Duty levels.
    localparam logic [DUTY_W-1:0] DUTY_OFF   = 10'd0;
    localparam logic [DUTY_W-1:0] DUTY_FULL  = 10'd1023;
    localparam logic [DUTY_W-1:0] DUTY_FORCE = 10'd2;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_ON_DELAY   = 3'd0;
    localparam logic [IDX_W-1:0] REG_OFF_DELAY  = 3'd1;
    localparam logic [IDX_W-1:0] REG_HYSTERESIS = 3'd2;
    localparam logic [IDX_W-1:0] REG_SAFE_LOW   = 3'd3;
    localparam logic [IDX_W-1:0] REG_SAFE_HIGH  = 3'd4;
    localparam logic [IDX_W-1:0] REG_PUMP_ON    = 3'd5;
    localparam logic [IDX_W-1:0] REG_PUMP_OFF   = 3'd6;

    // Register reset values.
    localparam logic [DELAY_W-1:0]       ON_DELAY_RST   = 16'd500;
    localparam logic [DELAY_W-1:0]       OFF_DELAY_RST  = 16'd5;
    localparam logic [HYST_W-1:0]        HYST_RST       = 8'd4;
    localparam logic signed [TEMP_W-1:0] SAFE_LOW_RST   = 12'sd0;
    localparam logic signed [TEMP_W-1:0] SAFE_HIGH_RST  = 12'sd800;
    localparam logic [TIME_W-1:0]        PUMP_ON_RST    = 32'd30000;
    localparam logic [TIME_W-1:0]        PUMP_OFF_RST   = 32'd10000;

    // Configuration as seen by the evaluation logic.
    typedef struct packed {
        logic [DELAY_W-1:0]       on_delay_ms;
        logic [DELAY_W-1:0]       off_delay_ms;
        logic [HYST_W-1:0]        hysteresis;
        logic signed [TEMP_W-1:0] safe_temp_low;
        logic signed [TEMP_W-1:0] safe_temp_high;
        logic [TIME_W-1:0]        pump_on_time_ms;
        logic [TIME_W-1:0]        pump_off_time_ms;
    } cfg_t;

    // One evaluation request.
    typedef struct packed {
        logic [TIME_W-1:0]        now_ms;
        logic                     level_low_ok;
        logic                     level_high;
        logic signed [TEMP_W-1:0] reference_temp;
        logic signed [TEMP_W-1:0] compared_temp;
    } item_t;

    // One evaluation result.
    typedef struct packed {
        logic [DUTY_W-1:0] heater_duty;
        logic              pump_on;
        logic              heat_permitted;
    } result_t;

endpackage

[hdl/hip_cfg_regs.sv]
// Configuration register file for the heater interlock block.
// Depends on hip_pkg for the register map and the cfg_t record.
module hip_cfg_regs
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        wr_en,
    input  logic [hip_pkg::IDX_W-1:0]   wr_index,
    input  logic [hip_pkg::DATA_W-1:0]  wr_data,
    output hip_pkg::cfg_t               cfg
);
    import hip_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write; an unknown index leaves everything as it was.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                REG_ON_DELAY:   cfg_next.on_delay_ms      = wr_data[DELAY_W-1:0];
                REG_OFF_DELAY:  cfg_next.off_delay_ms     = wr_data[DELAY_W-1:0];
                REG_HYSTERESIS: cfg_next.hysteresis       = wr_data[HYST_W-1:0];
                REG_SAFE_LOW:   cfg_next.safe_temp_low    = $signed(wr_data[TEMP_W-1:0]);
                REG_SAFE_HIGH:  cfg_next.safe_temp_high   = $signed(wr_data[TEMP_W-1:0]);
                REG_PUMP_ON:    cfg_next.pump_on_time_ms  = wr_data[TIME_W-1:0];
                REG_PUMP_OFF:   cfg_next.pump_off_time_ms = wr_data[TIME_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage with its documented reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.on_delay_ms      <= ON_DELAY_RST;
            cfg_reg.off_delay_ms     <= OFF_DELAY_RST;
            cfg_reg.hysteresis       <= HYST_RST;
            cfg_reg.safe_temp_low    <= SAFE_LOW_RST;
            cfg_reg.safe_temp_high   <= SAFE_HIGH_RST;
            cfg_reg.pump_on_time_ms  <= PUMP_ON_RST;
            cfg_reg.pump_off_time_ms <= PUMP_OFF_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/hip_core.sv]
// Interlock, hysteresis controller and pump sequencer with their state registers.
// Produces the result of one evaluation combinationally; state advances on step.
// Depends on hip_pkg for cfg_t, item_t and result_t.
module hip_core
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  hip_pkg::item_t   item,
    input  hip_pkg::cfg_t    cfg,
    output hip_pkg::result_t result
);
    import hip_pkg::*;

    localparam int unsigned EXT_W = TEMP_W + 2;

    logic [TIME_W-1:0] safe_since_reg,   safe_since_next;
    logic [TIME_W-1:0] unsafe_since_reg, unsafe_since_next;
    logic              permit_reg,       permit_next;
    logic [DUTY_W-1:0] duty_reg,         duty_next;
    logic              pump_reg,         pump_next;
    logic [TIME_W-1:0] last_toggle_reg,  last_toggle_next;

    logic                    safe;
    logic                    withdrawn;
    logic [TIME_W-1:0]       safe_elapsed;
    logic [TIME_W-1:0]       unsafe_elapsed;
    logic [TIME_W-1:0]       pump_elapsed;
    logic [TIME_W-1:0]       pump_period;
    logic signed [EXT_W-1:0] ref_ext;
    logic signed [EXT_W-1:0] cmp_ext;
    logic signed [EXT_W-1:0] hyst_ext;
    logic signed [EXT_W-1:0] band_high;
    logic signed [EXT_W-1:0] band_low;
    logic [DUTY_W-1:0]       duty_ctrl;

    // Safety condition and elapsed times, all modulo 2^32.
    assign safe = item.level_low_ok
                  && (item.reference_temp > cfg.safe_temp_low)
                  && (item.reference_temp < cfg.safe_temp_high);
    assign safe_elapsed   = item.now_ms - safe_since_reg;
    assign unsafe_elapsed = item.now_ms - unsafe_since_reg;
    assign pump_elapsed   = item.now_ms - last_toggle_reg;
    assign pump_period    = pump_reg ? cfg.pump_on_time_ms : cfg.pump_off_time_ms;

    // Hysteresis band around the reference, widened so no sum overflows.
    assign ref_ext   = EXT_W'(item.reference_temp);
    assign cmp_ext   = EXT_W'(item.compared_temp);
    assign hyst_ext  = $signed({{(EXT_W-HYST_W){1'b0}}, cfg.hysteresis});
    assign band_high = ref_ext + hyst_ext;
    assign band_low  = ref_ext - hyst_ext;

    // Bang-bang decision: off above the band, full below it, else hold.
    always_comb
    begin
        if (cmp_ext >= band_high)
        begin
            duty_ctrl = DUTY_OFF;
        end
        else if (cmp_ext <= band_low)
        begin
            duty_ctrl = DUTY_FULL;
        end
        else
        begin
            duty_ctrl = duty_reg;
        end
    end

    // Interlock timers and permit. A start time of zero reads as unset.
    always_comb
    begin
        safe_since_next   = safe_since_reg;
        unsafe_since_next = unsafe_since_reg;
        permit_next       = permit_reg;
        withdrawn         = 1'b0;
        if (safe)
        begin
            unsafe_since_next = '0;
            if (!permit_reg)
            begin
                if (safe_since_reg == '0)
                begin
                    safe_since_next = item.now_ms;
                end
                else if (safe_elapsed >= TIME_W'(cfg.on_delay_ms))
                begin
                    permit_next = 1'b1;
                end
            end
        end
        else
        begin
            safe_since_next = '0;
            if (permit_reg)
            begin
                if (unsafe_since_reg == '0)
                begin
                    unsafe_since_next = item.now_ms;
                end
                else if (unsafe_elapsed >= TIME_W'(cfg.off_delay_ms))
                begin
                    permit_next = 1'b0;
                    withdrawn   = 1'b1;
                end
            end
        end
    end

    // Duty and pump. Without a permit the duty drops and the pump holds.
    always_comb
    begin
        duty_next        = duty_reg;
        pump_next        = pump_reg;
        last_toggle_next = last_toggle_reg;
        if (withdrawn || !permit_next)
        begin
            duty_next = DUTY_OFF;
        end
        else
        begin
            duty_next = duty_ctrl;
            if (duty_ctrl > DUTY_FORCE)
            begin
                pump_next = 1'b1;
            end
            else if (pump_elapsed >= pump_period)
            begin
                last_toggle_next = item.now_ms;
                pump_next        = !pump_reg;
            end
        end
    end

    // State registers advance once per accepted evaluation.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            safe_since_reg   <= '0;
            unsafe_since_reg <= '0;
            permit_reg       <= 1'b0;
            duty_reg         <= '0;
            pump_reg         <= 1'b0;
            last_toggle_reg  <= '0;
        end
        else if (step)
        begin
            safe_since_reg   <= safe_since_next;
            unsafe_since_reg <= unsafe_since_next;
            permit_reg       <= permit_next;
            duty_reg         <= duty_next;
            pump_reg         <= pump_next;
            last_toggle_reg  <= last_toggle_next;
        end
    end

    assign result.heater_duty    = duty_next;
    assign result.pump_on        = pump_next;
    assign result.heat_permitted = permit_next;

endmodule

[hdl/heater_interlock_hysteresis_pump.sv]
// Top level of the heater interlock, hysteresis controller and pump block.
// Instantiates hip_cfg_regs and hip_core; depends on hip_pkg.
//
// Usage:
//   The s_ stream carries one control evaluation per transaction. Each is
//   captured in an input register, evaluated from there and its result is
//   loaded into the output register that drives the m_ stream.
//   m_tvalid rises as the result is loaded into the output register, and
//   the item waits in the input register while that register is stalled.
//   Throughput is one evaluation per cycle while the receiver keeps up: the
//   input register refills in the same cycle as its predecessor moves out.
//   The controller state (timers, permit, duty, pump) advances exactly once
//   per evaluation, as it moves into the output register.
//   When the receiver stalls, the result waits in the output register and
//   one more transaction waits in the input register; s_tready then drops.
//   The cfg channel writes one register per transaction and is always ready;
//   writes should only be made while no evaluation is in flight.
//   Reset clears both stages, the controller state and restores the default
//   register values.
module heater_interlock_hysteresis_pump
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata, from bit 0: now_ms[31:0], level_low_ok[32], level_high[33],
    // reference_temp[45:34], compared_temp[57:46], zeros[63:58].
    input  logic [hip_pkg::IN_DATA_W-1:0]   s_tdata,
    // Output stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata, from bit 0: heater_duty[9:0], pump_on[10], heat_permitted[11],
    // zeros[15:12].
    output logic [hip_pkg::OUT_DATA_W-1:0]  m_tdata,
    // Configuration write channel.
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [hip_pkg::IDX_W-1:0]       cfg_index,
    input  logic [hip_pkg::DATA_W-1:0]      cfg_data
);
    import hip_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t result;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    hip_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Handshake: the held item moves on when the output slot is free or emptying.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg.now_ms         <= s_tdata[31:0];
            item_reg.level_low_ok   <= s_tdata[32];
            item_reg.level_high     <= s_tdata[33];
            item_reg.reference_temp <= $signed(s_tdata[45:34]);
            item_reg.compared_temp  <= $signed(s_tdata[57:46]);
        end
    end

    // Evaluation and controller state.
    hip_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg),
        .result (result)
    );

    // Output stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_DATA_W - DUTY_W - 2){1'b0}},
                       out_reg.heat_permitted, out_reg.pump_on, out_reg.heater_duty};

endmodule
